FILE: hdl/nbmu_pkg.sv
// Package: shared types, constants and Q16.16 helpers for the neuron unit
package nbmu_pkg;
  localparam int MaxInputs = 64;
  localparam int SlotW = 6;
  localparam logic signed [31:0] OneQ = 32'sd65536;
  localparam logic signed [47:0] AccMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] AccMin = {1'b1, {47{1'b0}}};

  typedef enum logic [2:0] {
    CMD_LOAD = 3'd0, CMD_FWD = 3'd1, CMD_OGRAD = 3'd2,
    CMD_HGRAD = 3'd3, CMD_UPD = 3'd4, CMD_READ = 3'd5,
    CMD_RSV6 = 3'd6, CMD_RSV7 = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BIAS = 2'd0, KIND_INPUT = 2'd1, KIND_HIDDEN = 2'd2, KIND_OUTPUT = 2'd3
  } kind_e;

  localparam logic [1:0] RegLr = 2'd0;
  localparam logic [1:0] RegMom = 2'd1;
  localparam logic [1:0] RegKind = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_M1, ST_M2, ST_M3, ST_M4, ST_FIN, ST_OUT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round half up, floor shift, saturate
  function automatic logic signed [31:0] mulq_fix(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + 64'sd32768) >>> 16;
    return sat32(r);
  endfunction

  function automatic logic signed [31:0] sigmoid_q(input logic signed [47:0] x);
    logic [47:0] y;
    logic [47:0] f;
    y = x[47] ? 48'(-x) : 48'(x);
    if (y >= 48'd327680) f = 48'd65536;
    else if (y >= 48'd155648) f = (y >> 5) + 48'd55296;
    else if (y >= 48'd65536) f = (y >> 3) + 48'd40960;
    else f = (y >> 2) + 48'd32768;
    if (x[47]) f = 48'd65536 - f;
    return f[31:0];
  endfunction
endpackage

FILE: hdl/neuron_backprop_momentum_unit.sv
// Top level: sigmoid neuron, backprop with momentum, Q16.16
//
// Input channel (in_valid_i/in_ready_o) takes one command beat: cmd_i, slot_i,
// value_a_i, value_b_i, from_bias_i, last_term_i. Output channel
// (out_valid_o/out_ready_i) returns one beat per command: result_value_o and
// finished_o. Registers learning_rate, momentum, neuron_kind sit on the APB
// port at 0x0, 0x4, 0x8; write only while idle.
// Each command runs on one shared registered multiplier stepped by a small
// sequencer. Load, read and reserved codes pass ST_RD, ST_FIN and ST_OUT;
// forward, both gradients and update add ST_M1 to ST_M4 (up to three
// multiplies plus store reads). in_ready_o is low from acceptance until
// the cycle after the result beat is taken, so a new command is not taken
// until the previous result beat has been taken.
// A stalled receiver holds the result register and blocks new commands.
// Reset clears registers, accumulator, output, gradient and the 64 delta
// valid bits; the weight memory is left undefined.
module neuron_backprop_momentum_unit import nbmu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic [5:0]         slot_i,
  input  logic signed [31:0] value_a_i,
  input  logic signed [31:0] value_b_i,
  input  logic               from_bias_i,
  input  logic               last_term_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic               finished_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  state_e st_q, st_d;
  logic [16:0] lr_q, mom_q;
  logic [1:0] kind_q;
  cmd_e cmd_q;
  logic [SlotW-1:0] slot_q;
  logic [SlotW-1:0] rd_slot;
  logic signed [31:0] a_q, b_q;
  logic skip_q, last_q;
  logic signed [47:0] acc_q;
  logic signed [31:0] out_q, grad_q, t_q, w_q, dl_q, res_q;
  logic fin_q, oval_q;
  logic [MaxInputs-1:0] dvalid_q;
  logic signed [31:0] wmem [MaxInputs];
  logic signed [31:0] dmem [MaxInputs];
  logic signed [31:0] wrd_q, drd_q;
  logic signed [32:0] ma, mb;
  logic signed [31:0] mp;
  logic signed [31:0] cur_out;
  logic signed [31:0] nd, nw;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[3:2])
      RegLr:   prdata = {15'd0, lr_q};
      RegMom:  prdata = {15'd0, mom_q};
      RegKind: prdata = {30'd0, kind_q};
      default: prdata = 32'd0;
    endcase
  end

  assign cur_out = (kind_q == KIND_BIAS) ? OneQ : out_q;
  assign in_ready_o = (st_q == ST_IDLE);
  assign out_valid_o = oval_q;
  assign result_value_o = res_q;
  assign finished_o = fin_q;

  // read the addressed slot at the accepting edge so it is ready in ST_RD
  assign rd_slot = (st_q == ST_IDLE) ? slot_i : slot_q;

  nbmu_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(mp));

  // multiplier operand select per step
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_q)
      ST_RD: begin
        if (cmd_q == CMD_FWD) begin ma = 33'(a_q); mb = 33'(wrd_q); end
        else if (cmd_q == CMD_UPD) begin ma = {16'd0, lr_q}; mb = 33'(a_q); end
        else if (cmd_q == CMD_HGRAD) begin ma = 33'(a_q); mb = 33'(b_q); end
        else begin ma = 33'(cur_out); mb = 33'(OneQ) - 33'(cur_out); end
      end
      ST_M2: begin
        if (cmd_q == CMD_UPD) begin ma = 33'(t_q); mb = 33'(grad_q); end
        else if (cmd_q == CMD_OGRAD) begin
          ma = 33'(sat32(64'(a_q) - 64'(cur_out))); mb = 33'(t_q);
        end else begin ma = 33'(cur_out); mb = 33'(OneQ) - 33'(cur_out); end
      end
      ST_M3: begin
        if (cmd_q == CMD_UPD) begin ma = {16'd0, mom_q}; mb = 33'(dl_q); end
        else begin ma = 33'(sat32(64'(acc_q))); mb = 33'(mp); end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (in_valid_i) st_d = ST_RD;
      ST_RD: begin
        if (cmd_q == CMD_FWD || cmd_q == CMD_HGRAD || cmd_q == CMD_UPD ||
            cmd_q == CMD_OGRAD) st_d = ST_M1;
        else st_d = ST_FIN;
      end
      ST_M1: st_d = ST_M2;
      ST_M2: st_d = ST_M3;
      ST_M3: st_d = ST_M4;
      ST_M4: st_d = ST_FIN;
      ST_FIN: st_d = ST_OUT;
      ST_OUT: if (out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  assign nd = sat32(64'(t_q) + 64'(mp));
  assign nw = sat32(64'(wrd_q) + 64'(nd));

  always_ff @(posedge clk_i) begin
    wrd_q <= wmem[rd_slot];
    drd_q <= dmem[rd_slot];
    if (st_q == ST_FIN && cmd_q == CMD_LOAD) wmem[slot_q] <= a_q;
    if (st_q == ST_M4 && cmd_q == CMD_UPD) begin
      wmem[slot_q] <= nw;
      dmem[slot_q] <= nd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_e'(cmd_i);
      slot_q <= slot_i;
      a_q <= value_a_i;
      b_q <= value_b_i;
      skip_q <= from_bias_i;
      last_q <= last_term_i;
    end
    if (st_q == ST_M1) dl_q <= dvalid_q[slot_q] ? drd_q : 32'sd0;
    if (st_q == ST_M1) t_q <= mp;
    if (st_q == ST_M3) t_q <= mp;
    if (st_q == ST_M4) w_q <= (cmd_q == CMD_UPD) ? nw : mp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      lr_q <= 17'd9830;
      mom_q <= 17'd32768;
      kind_q <= KIND_HIDDEN;
      acc_q <= '0;
      out_q <= '0;
      grad_q <= '0;
      dvalid_q <= '0;
      oval_q <= 1'b0;
      res_q <= '0;
      fin_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          RegLr:   lr_q <= pwdata[16:0];
          RegMom:  mom_q <= pwdata[16:0];
          RegKind: kind_q <= pwdata[1:0];
          default: ;
        endcase
      end
      if (st_q == ST_M1) begin
        logic signed [48:0] s;
        s = 49'(acc_q) + 49'(mp);
        if ((cmd_q == CMD_FWD && kind_q != KIND_BIAS) ||
            (cmd_q == CMD_HGRAD && !skip_q)) begin
          if (s > 49'(AccMax)) acc_q <= AccMax;
          else if (s < 49'(AccMin)) acc_q <= AccMin;
          else acc_q <= s[47:0];
        end
      end
      if (st_q == ST_M4 && cmd_q == CMD_UPD) dvalid_q[slot_q] <= 1'b1;
      if (st_q == ST_FIN) begin
        oval_q <= 1'b1;
        unique case (cmd_q)
          CMD_LOAD: begin
            res_q <= a_q;
            fin_q <= 1'b0;
          end
          CMD_READ: begin
            res_q <= wrd_q;
            fin_q <= 1'b0;
          end
          CMD_UPD: begin
            res_q <= w_q;
            fin_q <= 1'b0;
          end
          CMD_FWD: begin
            if (last_q) begin
              logic signed [31:0] o;
              o = (kind_q == KIND_BIAS) ? OneQ : sigmoid_q(acc_q);
              out_q <= o;
              res_q <= o;
              fin_q <= 1'b1;
              acc_q <= '0;
            end else begin
              res_q <= '0;
              fin_q <= 1'b0;
            end
          end
          CMD_OGRAD: begin
            grad_q <= t_q;
            res_q <= t_q;
            fin_q <= 1'b1;
          end
          CMD_HGRAD: begin
            if (last_q) begin
              grad_q <= w_q;
              res_q <= w_q;
              fin_q <= 1'b1;
              acc_q <= '0;
            end else begin
              res_q <= '0;
              fin_q <= 1'b0;
            end
          end
          default: begin
            res_q <= '0;
            fin_q <= 1'b0;
          end
        endcase
      end
      if (oval_q && out_ready_i) oval_q <= 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted twice");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(result_value_o))
    else $error("result changed under stall");
endmodule

FILE: hdl/nbmu_mul.sv
// Shared registered Q16.16 multiplier with rounding and saturation
module nbmu_mul import nbmu_pkg::*; (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [31:0] p_o
);
  logic signed [31:0] p_q;
  logic signed [65:0] prod;
  assign prod = a_i * b_i;
  always_ff @(posedge clk_i) begin
    p_q <= mulq_fix(prod[63:0]);
  end
  assign p_o = p_q;
endmodule
